// ===== src/bsa_pkg.sv =====
package bsa_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int CELL_BITS = 8;
	localparam int CELL_W    = $clog2(CELL_BITS);
	localparam int NUM_CELLS = (MAX_SLOTS + CELL_BITS - 1) / CELL_BITS;
	localparam int CELL_ID_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int IDX_W     = CELL_ID_W + CELL_W;
	localparam int CAP_W     = ($clog2(MAX_SLOTS + 1) > 7) ? $clog2(MAX_SLOTS + 1) : 7;
	localparam int CMP_W     = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
	localparam int STRIDE_W  = 13;
	localparam int HANDLE_W  = 64;
	localparam int PROD_W    = IDX_W + STRIDE_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;
	localparam logic [1:0] OP_GET   = 2'd3;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_FULL         = 3'd1;
	localparam logic [2:0] ST_BAD_INDEX    = 3'd2;
	localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
	localparam logic [2:0] ST_NOT_INIT     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] slot_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  granted_slot;
		logic [63:0] slot_handle;
		logic [6:0]  in_use_count;
		logic [6:0]  free_count;
	} out_item_t;

	// command token moving down the cell chain
	typedef struct packed {
		logic             valid;
		logic             act;
		logic [1:0]       op;
		logic [CAP_W-1:0] cap;
		logic [IDX_W-1:0] idx;
		logic             found;
		logic [IDX_W-1:0] slot;
		logic             hit_busy;
	} cmd_t;

endpackage

// ===== src/bsa_cell.sv =====
module bsa_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bsa_pkg::CELL_ID_W-1:0]  cell_id,
	input  bsa_pkg::cmd_t                  cmd_in,
	output bsa_pkg::cmd_t                  cmd_out
);

	logic [bsa_pkg::CELL_BITS-1:0] busy_q;
	logic [bsa_pkg::CELL_BITS-1:0] busy_d;
	logic [bsa_pkg::CELL_BITS-1:0] cand;
	logic [bsa_pkg::CELL_W-1:0]    sel;
	logic [bsa_pkg::CELL_W-1:0]    loc;
	bsa_pkg::cmd_t                 cmd_d;
	bsa_pkg::cmd_t                 cmd_q;

	assign loc = cmd_in.idx[bsa_pkg::CELL_W-1:0];

	always_comb begin
		busy_d = busy_q;
		cmd_d  = cmd_in;
		sel    = '0;
		for (int j = 0; j < bsa_pkg::CELL_BITS; j++) begin
			cand[j] = !busy_q[j] &&
				(bsa_pkg::CMP_W'({cell_id, bsa_pkg::CELL_W'(j)}) < bsa_pkg::CMP_W'(cmd_in.cap));
		end
		for (int j = bsa_pkg::CELL_BITS - 1; j >= 0; j--) begin
			if (cand[j]) sel = bsa_pkg::CELL_W'(j);
		end
		if (cmd_in.valid && cmd_in.act) begin
			case (cmd_in.op)
				bsa_pkg::OP_ALLOC: begin
					if (!cmd_in.found && (|cand)) begin
						busy_d[sel] = 1'b1;
						cmd_d.found = 1'b1;
						cmd_d.slot  = {cell_id, sel};
					end
				end
				bsa_pkg::OP_FREE: begin
					if (cmd_in.idx[bsa_pkg::IDX_W-1:bsa_pkg::CELL_W] == cell_id) begin
						cmd_d.hit_busy = busy_q[loc];
						busy_d[loc]    = 1'b0;
					end
				end
				bsa_pkg::OP_RESET: busy_d = '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			cmd_q  <= '0;
		end else begin
			busy_q <= busy_d;
			cmd_q  <= cmd_d;
		end
	end

	assign cmd_out = cmd_q;

endmodule

// ===== src/bitmap_slot_allocator_core.sv =====
// First-fit slot allocator built as a chain of cells of eight busy bits each.
// The command token is registered in each cell in turn; in S_SCAN the result, count and handle
// product are registered, and in S_OUT the handle sum and the output item.
// One item in flight: in_ready is low from the accept until S_OUT loads the result, which waits on out_ready.
// Reset (arst_n low): all slots free, count zero, configuration registers zero;
// no clearing pass, the block is ready as soon as reset is released.
module bitmap_slot_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bsa_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bsa_pkg::out_item_t             out_item,
	input  logic                           cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_wdata
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

	state_t                          state_q;
	logic [6:0]                      capacity_q;
	logic [bsa_pkg::STRIDE_W-1:0]    stride_q;
	logic [bsa_pkg::HANDLE_W-1:0]    base_q;
	logic [bsa_pkg::CAP_W-1:0]       cnt_q;
	logic [bsa_pkg::CAP_W-1:0]       cap_q;
	logic [1:0]                      op_q;
	logic                            init_q;
	logic [2:0]                      status_q;
	logic [bsa_pkg::IDX_W-1:0]       slot_q;
	logic                            grant_q;
	logic                            hnd_en_q;
	logic [bsa_pkg::PROD_W-1:0]      prod_q;
	logic                            out_valid_q;
	bsa_pkg::out_item_t              out_item_q;

	logic [bsa_pkg::CAP_W-1:0]       cap_eff;
	logic                            accept;
	logic                            in_range;
	bsa_pkg::cmd_t                   chain [bsa_pkg::NUM_CELLS+1];
	bsa_pkg::cmd_t                   cmd_new;
	bsa_pkg::cmd_t                   res;
	logic [2:0]                      status_d;
	logic [bsa_pkg::IDX_W-1:0]       slot_d;
	logic [bsa_pkg::CAP_W-1:0]       cnt_d;
	logic                            grant_d;
	logic                            hnd_en_d;

	assign cap_eff = (bsa_pkg::CAP_W'(capacity_q) > bsa_pkg::CAP_W'(bsa_pkg::MAX_SLOTS)) ?
		bsa_pkg::CAP_W'(bsa_pkg::MAX_SLOTS) : bsa_pkg::CAP_W'(capacity_q);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = bsa_pkg::CMP_W'(in_item.slot_index) < bsa_pkg::CMP_W'(cap_eff);

	always_comb begin
		cmd_new       = '0;
		cmd_new.valid = accept;
		cmd_new.op    = in_item.opcode;
		cmd_new.cap   = cap_eff;
		cmd_new.idx   = bsa_pkg::IDX_W'(in_item.slot_index);
		if (cap_eff != '0) begin
			case (in_item.opcode)
				bsa_pkg::OP_ALLOC: cmd_new.act = (cnt_q < cap_eff);
				bsa_pkg::OP_FREE:  cmd_new.act = in_range;
				bsa_pkg::OP_RESET: cmd_new.act = 1'b1;
				bsa_pkg::OP_GET:   cmd_new.act = in_range;
				default:           cmd_new.act = 1'b0;
			endcase
		end
	end

	assign chain[0] = cmd_new;

	for (genvar k = 0; k < bsa_pkg::NUM_CELLS; k++) begin : g_cell
		bsa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (bsa_pkg::CELL_ID_W'(k)),
			.cmd_in  (chain[k]),
			.cmd_out (chain[k+1])
		);
	end

	assign res = chain[bsa_pkg::NUM_CELLS];

	always_comb begin
		status_d = bsa_pkg::ST_NOT_INIT;
		slot_d   = res.idx;
		cnt_d    = cnt_q;
		grant_d  = 1'b0;
		hnd_en_d = 1'b0;
		if (init_q) begin
			case (op_q)
				bsa_pkg::OP_ALLOC: begin
					if (res.found) begin
						status_d = bsa_pkg::ST_OK;
						slot_d   = res.slot;
						cnt_d    = cnt_q + 1'b1;
						grant_d  = 1'b1;
						hnd_en_d = 1'b1;
					end else begin
						status_d = bsa_pkg::ST_FULL;
					end
				end
				bsa_pkg::OP_FREE: begin
					if (!res.act) begin
						status_d = bsa_pkg::ST_BAD_INDEX;
					end else if (res.hit_busy) begin
						status_d = bsa_pkg::ST_OK;
						if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
					end else begin
						status_d = bsa_pkg::ST_ALREADY_FREE;
					end
				end
				bsa_pkg::OP_RESET: begin
					status_d = bsa_pkg::ST_OK;
					cnt_d    = '0;
				end
				default: begin
					if (res.act) begin
						status_d = bsa_pkg::ST_OK;
						hnd_en_d = 1'b1;
					end else begin
						status_d = bsa_pkg::ST_BAD_INDEX;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			stride_q   <= '0;
			base_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bsa_pkg::CFG_CAPACITY: capacity_q <= cfg_wdata[6:0];
				bsa_pkg::CFG_STRIDE:   stride_q   <= cfg_wdata[bsa_pkg::STRIDE_W-1:0];
				bsa_pkg::CFG_BASE:     base_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			cap_q       <= '0;
			op_q        <= bsa_pkg::OP_ALLOC;
			init_q      <= 1'b0;
			status_q    <= bsa_pkg::ST_OK;
			slot_q      <= '0;
			grant_q     <= 1'b0;
			hnd_en_q    <= 1'b0;
			prod_q      <= '0;
			out_item_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cap_q   <= cap_eff;
						op_q    <= in_item.opcode;
						init_q  <= (cap_eff != '0);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (res.valid) begin
						status_q <= status_d;
						slot_q   <= slot_d;
						cnt_q    <= cnt_d;
						grant_q  <= grant_d;
						hnd_en_q <= hnd_en_d;
						prod_q   <= bsa_pkg::PROD_W'(slot_d) * bsa_pkg::PROD_W'(stride_q);
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q              <= 1'b1;
						out_item_q.status        <= status_q;
						out_item_q.granted_slot  <= grant_q ? 6'(slot_q) : 6'd0;
						out_item_q.slot_handle   <= hnd_en_q ?
							base_q + bsa_pkg::HANDLE_W'(prod_q) : '0;
						out_item_q.in_use_count  <= 7'(cnt_q);
						out_item_q.free_count    <= (cap_q > cnt_q) ? 7'(cap_q - cnt_q) : 7'd0;
						state_q                  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== src/bsa_checker.sv =====
module bsa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bsa_pkg::out_item_t  out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// one item in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted during scan");

	// no result appears right after an accept
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// errors carry no handle and no grant
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != bsa_pkg::ST_OK) |->
			(out_item.slot_handle == '0) && (out_item.granted_slot == '0))
		else $error("error result with handle or grant");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
